// ===== rtl/pitsq_pkg.sv =====
// shared types, codes and constants for the counter-0 square wave sound core
// used by pitsq_ctrl, pitsq_datapath and the top level
`default_nettype none

package pitsq_pkg;

  localparam int INPUT_CLOCK_HZ_DEF = 894886;
  localparam int SAMPLE_RATE_HZ_DEF = 44100;
  localparam int BASE_AMPLITUDE_DEF = 8192;

  localparam int AMP_W  = 15;
  localparam int PROD_W = 22;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 2;

  // exact floor(x / 100) for any x below 2**22
  localparam logic [22:0] DIV100_MUL   = 23'd5368710;
  localparam int          DIV100_SHIFT = 29;

  typedef enum logic [1:0] {
    CMD_MEM  = 2'd0,
    CMD_IO   = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [IDX_W-1:0] REG_VOLUME = 2'd0;
  localparam logic [IDX_W-1:0] REG_PAN    = 2'd1;
  localparam logic [IDX_W-1:0] REG_FORCE  = 2'd2;

  localparam logic [7:0] MEM_PAGE     = 8'hE0;
  localparam logic [7:0] MEM_COUNT    = 8'h04;
  localparam logic [7:0] MEM_CONTROL  = 8'h07;
  localparam logic [7:0] MEM_GATE     = 8'h08;

  localparam logic [7:0] PORT_UNMAP   = 8'hE1;
  localparam logic [7:0] PORT_MAP_A   = 8'hE3;
  localparam logic [7:0] PORT_MAP_B   = 8'hE4;
  localparam logic [7:0] PORT_LOCK    = 8'hE5;
  localparam logic [7:0] PORT_UNLOCK  = 8'hE6;
  localparam logic [7:0] PORT_DISPLAY = 8'hCE;

  localparam logic [1:0] LOAD_NONE = 2'd0;
  localparam logic [1:0] LOAD_LSB  = 2'd1;
  localparam logic [1:0] LOAD_MSB  = 2'd2;
  localparam logic [1:0] LOAD_BOTH = 2'd3;

  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef struct packed {
    logic latch;
    logic exec;
    logic step;
    logic mul0;
    logic mul1;
    logic mul2;
    logic emit;
  } pitsq_cmd_t;

  typedef struct packed {
    cmd_t kind;
    logic silent;
    logic residue_ge;
    logic out_full;
  } pitsq_stat_t;

  function automatic logic [15:0] div100(input logic [PROD_W-1:0] x);
    logic [44:0] p;
    p = 45'(x) * 45'(DIV100_MUL);
    return p[44:DIV100_SHIFT];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pitsq_ctrl.sv =====
// sequencer for the square wave sound core: input handshake and step order
// depends on pitsq_pkg for the command and status structs
`default_nettype none

module pitsq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire pitsq_pkg::pitsq_stat_t stat,
  output pitsq_pkg::pitsq_cmd_t   ctl
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_STEP = 7'b0000100,
    ST_MUL0 = 7'b0001000,
    ST_MUL1 = 7'b0010000,
    ST_MUL2 = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (stat.kind == pitsq_pkg::CMD_TICK) begin
          state_next = stat.silent ? ST_EMIT : ST_STEP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_STEP: if (!stat.residue_ge) state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_EMIT;
      ST_EMIT: if (!stat.out_full) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign ctl.latch = (state == ST_IDLE) && s_tvalid;
  assign ctl.exec  = (state == ST_EXEC);
  assign ctl.step  = (state == ST_STEP);
  assign ctl.mul0  = (state == ST_MUL0);
  assign ctl.mul1  = (state == ST_MUL1);
  assign ctl.mul2  = (state == ST_MUL2);
  assign ctl.emit  = (state == ST_EMIT);

endmodule

`default_nettype wire

// ===== rtl/pitsq_datapath.sv =====
// timer state, write decoding, counter stepping, sample scaling, output register
// depends on pitsq_pkg; driven by pitsq_ctrl
`default_nettype none

module pitsq_datapath #(
  parameter int INPUT_CLOCK_HZ = pitsq_pkg::INPUT_CLOCK_HZ_DEF,
  parameter int SAMPLE_RATE_HZ = pitsq_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int BASE_AMPLITUDE = pitsq_pkg::BASE_AMPLITUDE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [23:0]                   s_tdata,
  input  wire logic [1:0]                    s_tuser,
  input  wire logic                          cfg_valid,
  input  wire logic [pitsq_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pitsq_pkg::CFG_W-1:0]   cfg_data,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [39:0]                        m_tdata,
  input  wire pitsq_pkg::pitsq_cmd_t         ctl,
  output pitsq_pkg::pitsq_stat_t             stat
);

  localparam int RES_W = $clog2(INPUT_CLOCK_HZ + SAMPLE_RATE_HZ);
  localparam logic [RES_W-1:0] ICLK = RES_W'(INPUT_CLOCK_HZ);
  localparam logic [RES_W-1:0] SRATE = RES_W'(SAMPLE_RATE_HZ);
  localparam logic [pitsq_pkg::AMP_W-1:0] BASE_C = pitsq_pkg::AMP_W'(BASE_AMPLITUDE);

  // latched item
  pitsq_pkg::cmd_t cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;

  // configuration
  logic [6:0] volume;
  logic [6:0] pan;
  logic       force_active;

  // timer state
  logic        gate_open, counter_running, square_mode, output_level;
  logic [16:0] reload_count;
  logic [15:0] down_count;
  logic [RES_W-1:0] cycle_residue;
  logic [1:0]  load_kind;
  logic        awaiting_high_byte;
  logic [7:0]  held_low_byte;
  logic        legacy_mode, periph_mapped, periph_locked;
  logic [7:0]  write_events;

  // scaling pipeline
  logic                          silent_q;
  logic [pitsq_pkg::PROD_W-1:0]  prod;
  logic [8:0]                    p256;
  logic [pitsq_pkg::AMP_W-1:0]   amp;
  logic [23:0]                   mag_l, mag_r;

  // output register
  logic        out_valid;
  logic [15:0] out_left, out_right;
  logic [7:0]  out_events;

  logic        active, mem_hit, silent, fix_down;
  logic [7:0]  lo;
  logic [15:0] half_up, half_dn, dc_dec;
  logic        ctl_ok;
  logic        lc_req;
  logic [15:0] lc_val;
  logic [16:0] lc_full;
  logic [6:0]  vol_sat, pan_sat;
  logic [15:0] left_val, right_val;

  function automatic logic [15:0] scale(input logic high, input logic [23:0] m);
    logic [24:0] t;
    t = {1'b0, m} + 25'd255;
    if (high) return m[23:8];
    return 16'(16'd0 - t[23:8]);
  endfunction

  always_comb begin
    active   = force_active || (legacy_mode && periph_mapped && !periph_locked);
    lo       = addr_q[7:0];
    mem_hit  = (addr_q[15:8] == pitsq_pkg::MEM_PAGE) && (lo >= pitsq_pkg::MEM_COUNT)
               && (lo <= pitsq_pkg::MEM_GATE);
    silent   = !(gate_open && counter_running && square_mode
                 && (reload_count[16:1] != 16'd0) && active);
    half_up  = 16'((18'(reload_count) + 18'd1) >> 1);
    half_dn  = reload_count[16:1];
    fix_down = (down_count == 16'd0) || (17'(down_count) > reload_count);
    dc_dec   = down_count - 16'd1;
    ctl_ok   = (data_q[7:6] == 2'd0) && (data_q[5:4] != 2'd0);

    // count byte write
    lc_req = 1'b0;
    lc_val = 16'd0;
    case (load_kind)
      pitsq_pkg::LOAD_LSB: begin
        lc_req = 1'b1;
        lc_val = {reload_count[15:8], data_q};
      end
      pitsq_pkg::LOAD_MSB: begin
        lc_req = 1'b1;
        lc_val = {data_q, reload_count[7:0]};
      end
      pitsq_pkg::LOAD_BOTH: begin
        lc_req = awaiting_high_byte;
        lc_val = {data_q, held_low_byte};
      end
      default: begin
        lc_req = 1'b0;
      end
    endcase
    // a count of zero means 0x10000
    lc_full = (lc_val == 16'd0) ? 17'h10000 : 17'(lc_val);

    vol_sat = (volume > pitsq_pkg::PCT_MAX) ? pitsq_pkg::PCT_MAX : volume;
    pan_sat = (pan > pitsq_pkg::PCT_MAX) ? pitsq_pkg::PCT_MAX : pan;

    left_val  = silent_q ? 16'd0 : scale(output_level, mag_l);
    right_val = silent_q ? 16'd0 : scale(output_level, mag_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q  <= pitsq_pkg::cmd_t'(s_tuser);
      addr_q <= s_tdata[15:0];
      data_q <= s_tdata[23:16];
    end
    if (ctl.mul0) begin
      prod <= pitsq_pkg::PROD_W'(BASE_C) * pitsq_pkg::PROD_W'(vol_sat);
      p256 <= 9'(pitsq_pkg::div100(pitsq_pkg::PROD_W'({pan_sat, 8'd0})));
    end
    if (ctl.mul1) begin
      amp <= pitsq_pkg::AMP_W'(pitsq_pkg::div100(prod));
    end
    if (ctl.mul2) begin
      mag_l <= 24'(amp) * 24'(9'd256 - p256);
      mag_r <= 24'(amp) * 24'(p256);
    end
    if (ctl.emit && !out_valid) begin
      out_left   <= left_val;
      out_right  <= right_val;
      out_events <= write_events;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume             <= 7'd100;
      pan                <= 7'd50;
      force_active       <= 1'b0;
      gate_open          <= 1'b0;
      counter_running    <= 1'b0;
      square_mode        <= 1'b0;
      reload_count       <= 17'd0;
      down_count         <= 16'd0;
      output_level       <= 1'b1;
      cycle_residue      <= '0;
      load_kind          <= pitsq_pkg::LOAD_NONE;
      awaiting_high_byte <= 1'b0;
      held_low_byte      <= 8'd0;
      legacy_mode        <= 1'b1;
      periph_mapped      <= 1'b1;
      periph_locked      <= 1'b0;
      write_events       <= 8'd0;
      silent_q           <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pitsq_pkg::REG_VOLUME: volume <= cfg_data;
          pitsq_pkg::REG_PAN:    pan <= cfg_data;
          pitsq_pkg::REG_FORCE:  force_active <= cfg_data[0];
          default: ;
        endcase
      end

      if (ctl.exec) begin
        case (cmd_q)
          pitsq_pkg::CMD_MEM: begin
            if (mem_hit) begin
              write_events <= write_events + 8'd1;
              if (active) begin
                case (lo)
                  pitsq_pkg::MEM_COUNT: begin
                    if (load_kind == pitsq_pkg::LOAD_BOTH) begin
                      awaiting_high_byte <= !awaiting_high_byte;
                      if (!awaiting_high_byte) held_low_byte <= data_q;
                    end
                    if (lc_req) begin
                      reload_count    <= lc_full;
                      down_count      <= 16'((18'(lc_full) + 18'd1) >> 1);
                      output_level    <= 1'b1;
                      counter_running <= 1'b1;
                    end
                  end
                  pitsq_pkg::MEM_CONTROL: begin
                    if (ctl_ok) begin
                      load_kind          <= data_q[5:4];
                      awaiting_high_byte <= 1'b0;
                      square_mode        <= (data_q[3:1] == 3'd3);
                      counter_running    <= 1'b0;
                      output_level       <= 1'b1;
                    end
                  end
                  pitsq_pkg::MEM_GATE: gate_open <= data_q[0];
                  default: ;
                endcase
              end
            end
          end
          pitsq_pkg::CMD_IO: begin
            case (lo)
              pitsq_pkg::PORT_UNMAP: periph_mapped <= 1'b0;
              pitsq_pkg::PORT_MAP_A, pitsq_pkg::PORT_MAP_B: begin
                periph_mapped <= 1'b1;
                periph_locked <= 1'b0;
              end
              pitsq_pkg::PORT_LOCK:    periph_locked <= 1'b1;
              pitsq_pkg::PORT_UNLOCK:  periph_locked <= 1'b0;
              pitsq_pkg::PORT_DISPLAY: legacy_mode <= data_q[3];
              default: ;
            endcase
          end
          pitsq_pkg::CMD_TICK: begin
            silent_q <= silent;
            if (!silent) begin
              cycle_residue <= cycle_residue + ICLK;
              if (fix_down) down_count <= half_up;
            end
          end
          default: ;
        endcase
      end

      // one input-clock cycle of the counter per step
      if (ctl.step && stat.residue_ge) begin
        cycle_residue <= cycle_residue - SRATE;
        if (dc_dec == 16'd0) begin
          output_level <= !output_level;
          down_count   <= output_level ? half_dn : half_up;
        end else begin
          down_count <= dc_dec;
        end
      end

      if (out_valid && m_tready) out_valid <= 1'b0;
      if (ctl.emit && !out_valid) out_valid <= 1'b1;
    end
  end

  assign stat.kind       = cmd_q;
  assign stat.silent     = silent;
  assign stat.residue_ge = (cycle_residue >= SRATE);
  assign stat.out_full   = out_valid;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_events, out_right, out_left};

  a_residue_reduced: assert property (@(posedge clk) disable iff (rst)
    ctl.mul0 |-> (cycle_residue < SRATE))
    else $error("residue not reduced below the sample rate after stepping");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> (down_count != 16'd0))
    else $error("down count is zero while stepping");

  a_running_loaded: assert property (@(posedge clk) disable iff (rst)
    counter_running |-> (reload_count != 17'd0))
    else $error("counter running without a loaded count");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && !out_valid && silent_q) |=> (out_left == 16'd0 && out_right == 16'd0))
    else $error("silent tick produced a nonzero sample");

endmodule

`default_nettype wire

// ===== rtl/pit_counter0_square_wave_sound_core.sv =====
// top level of the counter-0 square wave sound core
// instantiates pitsq_ctrl and pitsq_datapath; depends on pitsq_pkg
`default_nettype none

// Square-wave sound source modeled on counter 0 of an 8253 timer in mode 3.
// Input transactions carry a kind in s_tuser (memory write, port write, sample
// tick); only sample ticks produce an output transaction, a stereo sample plus
// the running count of E004..E008 writes. Memory and port writes are carried
// out in EXEC, after which the core returns to IDLE. A silent tick goes from
// EXEC to EMIT; a sounding tick passes through EXEC, STEP, MUL0, MUL1, MUL2 and
// EMIT. In STEP the counter advances N = (residue + INPUT_CLOCK_HZ) /
// SAMPLE_RATE_HZ input-clock cycles for that sample, one cycle per clock in
// a single subtract-and-decrement step. A tick also waits while the output
// register still holds an untaken sample. Configuration writes are always ready.
module pit_counter0_square_wave_sound_core #(
  parameter int INPUT_CLOCK_HZ = pitsq_pkg::INPUT_CLOCK_HZ_DEF,
  parameter int SAMPLE_RATE_HZ = pitsq_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int BASE_AMPLITUDE = pitsq_pkg::BASE_AMPLITUDE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [23:0]                  s_tdata,   // address[15:0], data[23:16]
  input  wire logic [1:0]                   s_tuser,   // cmd[1:0]
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [39:0]                       m_tdata,   // left_sample[15:0],
                                                       // right_sample[31:16],
                                                       // event_count[39:32]
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pitsq_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [pitsq_pkg::CFG_W-1:0]  cfg_data
);

  pitsq_pkg::pitsq_cmd_t  ctl;
  pitsq_pkg::pitsq_stat_t stat;

  assign cfg_ready = 1'b1;

  pitsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  pitsq_datapath #(
    .INPUT_CLOCK_HZ (INPUT_CLOCK_HZ),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
    .BASE_AMPLITUDE (BASE_AMPLITUDE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

`default_nettype wire
